>>> sv/vcc_pkg.sv
// ----------------------------------------------------------------------------
// vcc_pkg
// Shared types, codes and constants of the vending controller with change:
// request and response words, outcome codes, controller/datapath handshake.
// ----------------------------------------------------------------------------
`default_nettype none

package vcc_pkg;

   // product slots; the index field is three bits wide
   localparam int SLOT_W       = 3;
   localparam int SLOT_COUNT   = 2 ** SLOT_W;
   localparam int NUM_PRODUCTS = 8;
   localparam int RANGE_W      = 9;

   // request actions
   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_SELECT = 2'd1;
   localparam logic [1:0] ACT_INSERT = 2'd2;
   localparam logic [1:0] ACT_STOCK  = 2'd3;

   // response kinds
   localparam logic [2:0] KIND_STATUS    = 3'd0;
   localparam logic [2:0] KIND_COIN      = 3'd1;
   localparam logic [2:0] KIND_DISPENSED = 3'd2;
   localparam logic [2:0] KIND_REFUNDED  = 3'd3;
   localparam logic [2:0] KIND_OWED      = 3'd4;
   localparam logic [2:0] KIND_CANCELLED = 3'd5;
   localparam logic [2:0] KIND_ERROR     = 3'd6;

   // coin sequencing
   localparam logic [2:0] COIN_FIRST = 3'd0;
   localparam logic [2:0] COIN_LAST  = 3'd7;

   // rest / 200 as ((rest >> 3) * 5243) >> 17, exact for any 16-bit rest
   localparam logic [12:0] Q200_MULT = 13'd5243;
   localparam int          Q200_SHIFT = 17;

   typedef struct packed {
      logic [1:0]  action;
      logic [2:0]  product_index;
      logic [13:0] price_cents;
      logic [7:0]  stock_count;
      logic [13:0] amount_cents;
   } vcc_req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  coin_value;
      logic [8:0]  coin_count;
      logic [15:0] money_cents;
      logic [7:0]  stock_left;
      logic        last;
   } vcc_rsp_type;

   // what the current word turns into
   typedef enum logic [2:0] {
      OUT_ERROR,
      OUT_LOAD,
      OUT_STOCK,
      OUT_SELECT,
      OUT_CANCEL,
      OUT_OWED,
      OUT_REFUND,
      OUT_PAY
   } vcc_outcome_type;

   // controller to datapath
   typedef struct packed {
      logic take_item;
      logic commit;
      logic pay_setup;
      logic div_load;
      logic coin_step;
      logic disp_emit;
   } vcc_cmd_type;

   // datapath to controller
   typedef struct packed {
      vcc_outcome_type outcome;
      logic            can_emit;
      logic            coin_nonzero;
      logic            coin_last;
   } vcc_sts_type;

   // euro denominations, largest first
   function automatic logic [7:0] coin_value(input logic [2:0] idx);
      logic [7:0] val;
      unique case (idx)
         3'd0:    val = 8'd200;
         3'd1:    val = 8'd100;
         3'd2:    val = 8'd50;
         3'd3:    val = 8'd20;
         3'd4:    val = 8'd10;
         3'd5:    val = 8'd5;
         3'd6:    val = 8'd2;
         default: val = 8'd1;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

>>> sv/vending_controller_with_change_unit.sv
// Responses: a load, select, restock or insert that does not complete a sale
//   gives its one word; a sale gives coin words, then its dispense word, one
//   coin type per cycle while the output register can take a word.
// Flow: one word at a time; the next is taken when the last word of the
//   previous one is in the output register.
// Reset: synchronous; clears prices, stock, selection and paid total.
// ----------------------------------------------------------------------------
// vending_controller_with_change_unit
// Vending controller with price/stock table and greedy euro change output.
// ----------------------------------------------------------------------------
`default_nettype none

module vending_controller_with_change_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire vcc_pkg::vcc_req_type req_word,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      vcc_pkg::vcc_rsp_type rsp_word
);

   vcc_pkg::vcc_cmd_type cmd;
   vcc_pkg::vcc_sts_type sts;

   // sequencer
   vcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tables and arithmetic
   vcc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .cmd       (cmd),
      .sts       (sts)
   );

`ifndef SYNTHESIS
   // a word is never written over an untaken one
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit || cmd.disp_emit) |-> sts.can_emit)
      else $error("response written while output register is held");

   // one word at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new word accepted while busy");

   // a sale always goes on to the quotient load
   assert property (@(posedge clock) disable iff (reset)
      cmd.pay_setup |=> cmd.div_load)
      else $error("sale setup not followed by quotient load");

   // at most one datapath command per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take_item, cmd.commit, cmd.pay_setup, cmd.div_load,
                cmd.coin_step, cmd.disp_emit}))
      else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

>>> sv/vcc_ctrl.sv
// ----------------------------------------------------------------------------
// vcc_ctrl
// Sequencer of the vending controller: takes a word, lets the datapath judge
// it, and walks change coins one denomination per cycle unless output is held.
// ----------------------------------------------------------------------------
`default_nettype none

module vcc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire vcc_pkg::vcc_sts_type sts,
   output      vcc_pkg::vcc_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_COIN,
      ST_DISP
   } state_type;

   state_type state_ff;
   state_type state_in;

   // commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (sts.outcome == vcc_pkg::OUT_PAY) begin
               cmd.pay_setup = 1'b1;
               state_in      = ST_DIV;
            end else if (sts.can_emit) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_load = 1'b1;
            state_in     = ST_COIN;
         end
         ST_COIN: begin
            // unused denominations pass without a word
            if (!sts.coin_nonzero || sts.can_emit) begin
               cmd.coin_step = 1'b1;
               if (sts.coin_last) begin
                  state_in = ST_DISP;
               end
            end
         end
         ST_DISP: begin
            if (sts.can_emit) begin
               cmd.disp_emit = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/vcc_datapath.sv
// ----------------------------------------------------------------------------
// vcc_datapath
// Price and stock tables, selection and paid total, change arithmetic and the
// response output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vcc_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire vcc_pkg::vcc_req_type req_word,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      vcc_pkg::vcc_rsp_type rsp_word,
   input  wire vcc_pkg::vcc_cmd_type cmd,
   output      vcc_pkg::vcc_sts_type sts
);

   // control state
   logic [13:0] price_ff [vcc_pkg::SLOT_COUNT];
   logic [13:0] price_in [vcc_pkg::SLOT_COUNT];
   logic [7:0]  stock_ff [vcc_pkg::SLOT_COUNT];
   logic [7:0]  stock_in [vcc_pkg::SLOT_COUNT];
   logic [2:0]  chosen_ff, chosen_in;
   logic        picked_ff, picked_in;
   logic [15:0] paid_ff, paid_in;
   logic [2:0]  coin_idx_ff, coin_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // payload registers
   vcc_pkg::vcc_req_type item_ff, item_in;
   logic [15:0] rest_ff, rest_in;
   logic [15:0] change_ff, change_in;
   logic [7:0]  left_ff, left_in;
   logic [8:0]  q200_ff, q200_in;
   vcc_pkg::vcc_rsp_type rsp_word_ff, rsp_word_in;

   // evaluation signals
   logic [2:0]  addr;
   logic [13:0] rd_price;
   logic [7:0]  rd_stock;
   logic [16:0] sum_wide;
   logic [15:0] paid_sum;
   logic        slot_bad;
   logic        chosen_bad;
   vcc_pkg::vcc_outcome_type outcome;
   vcc_pkg::vcc_rsp_type single_word;

   // coin signals
   logic [7:0]  cval;
   logic [8:0]  small_cnt;
   logic [8:0]  cnt;
   logic [16:0] cmoney_wide;
   logic [15:0] cmoney;
   logic [25:0] q200_prod;
   logic        can_emit;
   logic        emit;

   // table read and saturating paid sum
   always_comb begin
      addr       = (item_ff.action == vcc_pkg::ACT_INSERT) ? chosen_ff
                                                           : item_ff.product_index;
      rd_price   = price_ff[addr];
      rd_stock   = stock_ff[addr];
      sum_wide   = 17'(paid_ff) + 17'(item_ff.amount_cents);
      paid_sum   = sum_wide[16] ? 16'hFFFF : sum_wide[15:0];
      slot_bad   = vcc_pkg::RANGE_W'(item_ff.product_index)
                   >= vcc_pkg::RANGE_W'(vcc_pkg::NUM_PRODUCTS);
      chosen_bad = vcc_pkg::RANGE_W'(chosen_ff)
                   >= vcc_pkg::RANGE_W'(vcc_pkg::NUM_PRODUCTS);
   end

   // classify the word
   always_comb begin
      if (item_ff.action != vcc_pkg::ACT_INSERT) begin
         priority if (slot_bad) begin
            outcome = vcc_pkg::OUT_ERROR;
         end else if (item_ff.action == vcc_pkg::ACT_LOAD) begin
            outcome = vcc_pkg::OUT_LOAD;
         end else if (item_ff.action == vcc_pkg::ACT_STOCK) begin
            outcome = vcc_pkg::OUT_STOCK;
         end else if (picked_ff && paid_ff != 16'd0) begin
            outcome = vcc_pkg::OUT_ERROR;
         end else begin
            outcome = vcc_pkg::OUT_SELECT;
         end
      end else begin
         priority if (!picked_ff || chosen_bad) begin
            outcome = vcc_pkg::OUT_ERROR;
         end else if (item_ff.amount_cents == 14'd0 && paid_ff == 16'd0) begin
            outcome = vcc_pkg::OUT_CANCEL;
         end else if (paid_sum < 16'(rd_price)) begin
            outcome = vcc_pkg::OUT_OWED;
         end else if (rd_stock == 8'd0) begin
            outcome = vcc_pkg::OUT_REFUND;
         end else begin
            outcome = vcc_pkg::OUT_PAY;
         end
      end
   end

   // single-word results
   always_comb begin
      single_word      = '0;
      single_word.last = 1'b1;
      unique case (outcome)
         vcc_pkg::OUT_LOAD: begin
            single_word.kind        = vcc_pkg::KIND_STATUS;
            single_word.money_cents = 16'(item_ff.price_cents);
            single_word.stock_left  = item_ff.stock_count;
         end
         vcc_pkg::OUT_STOCK: begin
            single_word.kind        = vcc_pkg::KIND_STATUS;
            single_word.money_cents = 16'(rd_price);
            single_word.stock_left  = item_ff.stock_count;
         end
         vcc_pkg::OUT_SELECT: begin
            single_word.kind        = vcc_pkg::KIND_STATUS;
            single_word.money_cents = 16'(rd_price);
            single_word.stock_left  = rd_stock;
         end
         vcc_pkg::OUT_CANCEL: begin
            single_word.kind       = vcc_pkg::KIND_CANCELLED;
            single_word.stock_left = rd_stock;
         end
         vcc_pkg::OUT_OWED: begin
            single_word.kind        = vcc_pkg::KIND_OWED;
            single_word.money_cents = 16'(rd_price) - paid_sum;
            single_word.stock_left  = rd_stock;
         end
         vcc_pkg::OUT_REFUND: begin
            single_word.kind        = vcc_pkg::KIND_REFUNDED;
            single_word.money_cents = paid_sum;
         end
         default: begin
            single_word.kind = vcc_pkg::KIND_ERROR;
         end
      endcase
   end

   // coin count for the current denomination
   always_comb begin
      cval      = vcc_pkg::coin_value(coin_idx_ff);
      q200_prod = 26'(rest_ff[15:3]) * 26'(vcc_pkg::Q200_MULT);
      // below the largest coin the rest stays under twice the denomination
      // or, for 20 and 2, under three times
      if (rest_ff >= {7'd0, cval, 1'b0}) begin
         small_cnt = 9'd2;
      end else if (rest_ff >= {8'd0, cval}) begin
         small_cnt = 9'd1;
      end else begin
         small_cnt = 9'd0;
      end
      cnt         = (coin_idx_ff == vcc_pkg::COIN_FIRST) ? q200_ff : small_cnt;
      cmoney_wide = 17'(cnt) * 17'(cval);
      cmoney      = cmoney_wide[15:0];
   end

   assign can_emit = !rsp_valid_ff || rsp_ready;
   assign emit     = cmd.commit || cmd.disp_emit || (cmd.coin_step && cnt != 9'd0);

   // next-state of tables, selection and sequencing
   always_comb begin
      price_in     = price_ff;
      stock_in     = stock_ff;
      chosen_in    = chosen_ff;
      picked_in    = picked_ff;
      paid_in      = paid_ff;
      coin_idx_in  = coin_idx_ff;
      item_in      = item_ff;
      rest_in      = rest_ff;
      change_in    = change_ff;
      left_in      = left_ff;
      q200_in      = q200_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.take_item) begin
         item_in = req_word;
      end

      // commit of a single-word outcome
      if (cmd.commit) begin
         unique case (outcome)
            vcc_pkg::OUT_LOAD: begin
               price_in[addr] = item_ff.price_cents;
               stock_in[addr] = item_ff.stock_count;
            end
            vcc_pkg::OUT_STOCK: begin
               stock_in[addr] = item_ff.stock_count;
            end
            vcc_pkg::OUT_SELECT: begin
               chosen_in = item_ff.product_index;
               picked_in = 1'b1;
               paid_in   = 16'd0;
            end
            vcc_pkg::OUT_CANCEL: begin
               picked_in = 1'b0;
            end
            vcc_pkg::OUT_OWED: begin
               paid_in = paid_sum;
            end
            vcc_pkg::OUT_REFUND: begin
               picked_in = 1'b0;
               paid_in   = 16'd0;
            end
            default: begin
            end
         endcase
      end

      // completed payment with stock on hand
      if (cmd.pay_setup) begin
         rest_in        = paid_sum - 16'(rd_price);
         change_in      = paid_sum - 16'(rd_price);
         left_in        = rd_stock - 8'd1;
         stock_in[addr] = rd_stock - 8'd1;
         picked_in      = 1'b0;
         paid_in        = 16'd0;
         coin_idx_in    = vcc_pkg::COIN_FIRST;
      end

      if (cmd.div_load) begin
         q200_in = q200_prod[vcc_pkg::Q200_SHIFT +: 9];
      end

      if (cmd.coin_step) begin
         rest_in     = rest_ff - cmoney;
         coin_idx_in = coin_idx_ff + 3'd1;
      end

      // output word; a skipped denomination leaves a held word untouched
      if (cmd.commit) begin
         rsp_word_in = single_word;
      end else if (cmd.coin_step && cnt != 9'd0) begin
         rsp_word_in.kind        = vcc_pkg::KIND_COIN;
         rsp_word_in.coin_value  = cval;
         rsp_word_in.coin_count  = cnt;
         rsp_word_in.money_cents = cmoney;
         rsp_word_in.stock_left  = left_ff;
         rsp_word_in.last        = 1'b0;
      end else if (cmd.disp_emit) begin
         rsp_word_in.kind        = vcc_pkg::KIND_DISPENSED;
         rsp_word_in.coin_value  = 8'd0;
         rsp_word_in.coin_count  = 9'd0;
         rsp_word_in.money_cents = change_ff;
         rsp_word_in.stock_left  = left_ff;
         rsp_word_in.last        = 1'b1;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < vcc_pkg::SLOT_COUNT; i++) begin
            price_ff[i] <= '0;
            stock_ff[i] <= '0;
         end
         chosen_ff    <= '0;
         picked_ff    <= 1'b0;
         paid_ff      <= '0;
         coin_idx_ff  <= vcc_pkg::COIN_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         price_ff     <= price_in;
         stock_ff     <= stock_in;
         chosen_ff    <= chosen_in;
         picked_ff    <= picked_in;
         paid_ff      <= paid_in;
         coin_idx_ff  <= coin_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rest_ff     <= rest_in;
      change_ff   <= change_in;
      left_ff     <= left_in;
      q200_ff     <= q200_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      sts.outcome      = outcome;
      sts.can_emit     = can_emit;
      sts.coin_nonzero = (cnt != 9'd0);
      sts.coin_last    = (coin_idx_ff == vcc_pkg::COIN_LAST);
   end

endmodule

`default_nettype wire

>>> tb/sv/vending_controller_with_change_unit_tb.sv
// ----------------------------------------------------------------------------
// vending_controller_with_change_unit_tb
// Self-checking bench for the vending controller. A short table of directed
// words is followed by random purchase sequences with random content and some
// stray words. Every accepted request is run through a cents-exact model of
// the price/stock table and greedy change, and every response word is checked
// field by field against the oldest expected word. The sender works in bursts
// and the receiver stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module vending_controller_with_change_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RAND_WORDS  = 75;
   localparam int HOLD_AT     = 60;
   localparam int HOLD_LEN    = 400;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN       = 30;
   localparam int DIR_ROWS    = 25;

   // euro denominations, largest first, one byte each
   localparam logic [63:0] COIN_LIST =
      {8'd200, 8'd100, 8'd50, 8'd20, 8'd10, 8'd5, 8'd2, 8'd1};

   typedef struct packed {
      vcc_pkg::vcc_req_type word;
      logic                 fixed;
      vcc_pkg::vcc_rsp_type fixed_rsp;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid;
   logic                 req_ready;
   vcc_pkg::vcc_req_type req_word;
   logic                 rsp_valid;
   logic                 rsp_ready;
   vcc_pkg::vcc_rsp_type rsp_word;

   // vending model state
   logic [13:0] price_mem [0:7];
   logic [7:0]  stock_mem [0:7];
   logic [2:0]  pick_slot;
   logic        pick_valid;
   logic [15:0] paid_sum;

   // words of the request just taken, and words still owed by the dut
   vcc_pkg::vcc_rsp_type word_buf [0:8];
   int                   word_cnt;
   vcc_pkg::vcc_rsp_type due_words [$];

   stim_row_type directed_tab [0:DIR_ROWS-1];
   stim_row_type stim_plan [$];
   int           taken_count;
   int           mismatch_count;
   int           quiet_cycles;
   int           gen_price [0:7];

   vending_controller_with_change_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic vcc_pkg::vcc_req_type mk_req(input logic [1:0] act,
                                                   input logic [2:0] slot,
                                                   input logic [13:0] price,
                                                   input logic [7:0] stock,
                                                   input logic [13:0] amount);
      vcc_pkg::vcc_req_type w;
      w.action        = act;
      w.product_index = slot;
      w.price_cents   = price;
      w.stock_count   = stock;
      w.amount_cents  = amount;
      return w;
   endfunction

   // one table row; the typed word is used only when fixed is set
   function automatic stim_row_type dir_row(input logic [1:0] act, input logic [2:0] slot,
                                            input logic [13:0] price, input logic [7:0] stock,
                                            input logic [13:0] amount, input logic fixed,
                                            input logic [2:0] kind, input logic [15:0] money,
                                            input logic [7:0] left);
      stim_row_type r;
      r.word                  = mk_req(act, slot, price, stock, amount);
      r.fixed                 = fixed;
      r.fixed_rsp.kind        = kind;
      r.fixed_rsp.coin_value  = '0;
      r.fixed_rsp.coin_count  = '0;
      r.fixed_rsp.money_cents = money;
      r.fixed_rsp.stock_left  = left;
      r.fixed_rsp.last        = 1'b1;
      return r;
   endfunction

   function automatic void add_word(input logic [2:0] kind, input logic [7:0] cval,
                                    input logic [8:0] ccount, input logic [15:0] money,
                                    input logic [7:0] left);
      word_buf[word_cnt].kind        = kind;
      word_buf[word_cnt].coin_value  = cval;
      word_buf[word_cnt].coin_count  = ccount;
      word_buf[word_cnt].money_cents = money;
      word_buf[word_cnt].stock_left  = left;
      word_buf[word_cnt].last        = 1'b0;
      word_cnt = word_cnt + 1;
   endfunction

   // vending model: updates the table and fills word_buf for one request word
   function automatic void vend_forecast(input vcc_pkg::vcc_req_type w);
      logic [16:0] total;
      logic [15:0] change;
      logic [15:0] rest;
      logic [7:0]  left;
      logic [7:0]  coin;
      logic [15:0] cnt;
      logic [2:0]  s;
      word_cnt = 0;
      s = pick_slot;
      if (w.action != vcc_pkg::ACT_INSERT) begin
         if (int'(w.product_index) >= vcc_pkg::NUM_PRODUCTS) begin
            add_word(vcc_pkg::KIND_ERROR, '0, '0, '0, '0);
         end else if (w.action == vcc_pkg::ACT_LOAD) begin
            price_mem[w.product_index] = w.price_cents;
            stock_mem[w.product_index] = w.stock_count;
            add_word(vcc_pkg::KIND_STATUS, '0, '0, 16'(w.price_cents), w.stock_count);
         end else if (w.action == vcc_pkg::ACT_STOCK) begin
            stock_mem[w.product_index] = w.stock_count;
            add_word(vcc_pkg::KIND_STATUS, '0, '0, 16'(price_mem[w.product_index]),
                     w.stock_count);
         end else if (pick_valid && paid_sum != 16'd0) begin
            // select while a payment is under way
            add_word(vcc_pkg::KIND_ERROR, '0, '0, '0, '0);
         end else begin
            pick_slot  = w.product_index;
            pick_valid = 1'b1;
            paid_sum   = '0;
            add_word(vcc_pkg::KIND_STATUS, '0, '0, 16'(price_mem[w.product_index]),
                     stock_mem[w.product_index]);
         end
      end else if (!pick_valid) begin
         add_word(vcc_pkg::KIND_ERROR, '0, '0, '0, '0);
      end else if (w.amount_cents == 14'd0 && paid_sum == 16'd0) begin
         pick_valid = 1'b0;
         add_word(vcc_pkg::KIND_CANCELLED, '0, '0, '0, stock_mem[s]);
      end else begin
         total = {1'b0, paid_sum} + 17'(w.amount_cents);
         if (total > 17'h0FFFF) total = 17'h0FFFF;
         paid_sum = total[15:0];
         if (paid_sum < 16'(price_mem[s])) begin
            add_word(vcc_pkg::KIND_OWED, '0, '0, 16'(price_mem[s]) - paid_sum,
                     stock_mem[s]);
         end else if (stock_mem[s] == 8'd0) begin
            // sold out: everything goes back
            add_word(vcc_pkg::KIND_REFUNDED, '0, '0, paid_sum, '0);
            pick_valid = 1'b0;
            paid_sum   = '0;
         end else begin
            // greedy change, one word per coin type used, then dispense
            change = paid_sum - 16'(price_mem[s]);
            rest   = change;
            left   = stock_mem[s] - 8'd1;
            for (int c = 0; c < 8; c++) begin
               coin = COIN_LIST[63 - 8*c -: 8];
               cnt  = rest / 16'(coin);
               if (cnt != 16'd0) begin
                  rest = rest - cnt * 16'(coin);
                  add_word(vcc_pkg::KIND_COIN, coin, cnt[8:0], cnt * 16'(coin), left);
               end
            end
            stock_mem[s] = left;
            add_word(vcc_pkg::KIND_DISPENSED, '0, '0, change, left);
            pick_valid = 1'b0;
            paid_sum   = '0;
         end
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic match_field(input string what, input int got, input int want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   // directed rows, then purchase sequences with random content and stray words
   task automatic build_plan();
      int           rand_words;
      int           s;
      int           price;
      int           paid;
      int           steps;
      int           amt;
      logic [7:0]   stock;
      logic         stop;
      stim_row_type r;
      directed_tab = '{
         // insert with nothing selected
         dir_row(vcc_pkg::ACT_INSERT, 3'd0, 14'd0, 8'd0, 14'd5, 1'b1,
                 vcc_pkg::KIND_ERROR, 16'd0, 8'd0),
         // select from the empty table after reset
         dir_row(vcc_pkg::ACT_SELECT, 3'd0, 14'd0, 8'd0, 14'd0, 1'b1,
                 vcc_pkg::KIND_STATUS, 16'd0, 8'd0),
         // zero before payment cancels
         dir_row(vcc_pkg::ACT_INSERT, 3'd0, 14'd0, 8'd0, 14'd0, 1'b1,
                 vcc_pkg::KIND_CANCELLED, 16'd0, 8'd0),
         // field extremes on load
         dir_row(vcc_pkg::ACT_LOAD, 3'd7, 14'd10000, 8'd255, 14'd0, 1'b1,
                 vcc_pkg::KIND_STATUS, 16'd10000, 8'd255),
         dir_row(vcc_pkg::ACT_LOAD, 3'd0, 14'd0, 8'd0, 14'd10000, 1'b1,
                 vcc_pkg::KIND_STATUS, 16'd0, 8'd0),
         dir_row(vcc_pkg::ACT_SELECT, 3'd0, 14'd0, 8'd0, 14'd0, 1'b0, '0, '0, '0),
         // zero stock refunds all
         dir_row(vcc_pkg::ACT_INSERT, 3'd0, 14'd0, 8'd0, 14'd5, 1'b1,
                 vcc_pkg::KIND_REFUNDED, 16'd5, 8'd0),
         dir_row(vcc_pkg::ACT_STOCK, 3'd0, 14'd9999, 8'd3, 14'd0, 1'b1,
                 vcc_pkg::KIND_STATUS, 16'd0, 8'd3),
         // free item, 388 cents in: every coin type comes back
         dir_row(vcc_pkg::ACT_SELECT, 3'd0, 14'd0, 8'd0, 14'd0, 1'b0, '0, '0, '0),
         dir_row(vcc_pkg::ACT_INSERT, 3'd0, 14'd0, 8'd0, 14'd388, 1'b0, '0, '0, '0),
         dir_row(vcc_pkg::ACT_LOAD, 3'd2, 14'd150, 8'd2, 14'd0, 1'b0, '0, '0, '0),
         dir_row(vcc_pkg::ACT_SELECT, 3'd2, 14'd0, 8'd0, 14'd0, 1'b0, '0, '0, '0),
         dir_row(vcc_pkg::ACT_INSERT, 3'd0, 14'd0, 8'd0, 14'd100, 1'b0, '0, '0, '0),
         // zero after payment reports what is owed
         dir_row(vcc_pkg::ACT_INSERT, 3'd0, 14'd0, 8'd0, 14'd0, 1'b0, '0, '0, '0),
         // select during payment
         dir_row(vcc_pkg::ACT_SELECT, 3'd3, 14'd0, 8'd0, 14'd0, 1'b1,
                 vcc_pkg::KIND_ERROR, 16'd0, 8'd0),
         // exact payment
         dir_row(vcc_pkg::ACT_INSERT, 3'd0, 14'd0, 8'd0, 14'd50, 1'b0, '0, '0, '0),
         dir_row(vcc_pkg::ACT_SELECT, 3'd7, 14'd0, 8'd0, 14'd0, 1'b0, '0, '0, '0),
         dir_row(vcc_pkg::ACT_INSERT, 3'd0, 14'd0, 8'd0, 14'd9999, 1'b0, '0, '0, '0),
         // largest change
         dir_row(vcc_pkg::ACT_INSERT, 3'd0, 14'd0, 8'd0, 14'd10000, 1'b0, '0, '0, '0),
         dir_row(vcc_pkg::ACT_STOCK, 3'd2, 14'd0, 8'd0, 14'd0, 1'b0, '0, '0, '0),
         dir_row(vcc_pkg::ACT_SELECT, 3'd2, 14'd0, 8'd0, 14'd0, 1'b0, '0, '0, '0),
         dir_row(vcc_pkg::ACT_INSERT, 3'd0, 14'd0, 8'd0, 14'd200, 1'b1,
                 vcc_pkg::KIND_REFUNDED, 16'd200, 8'd0),
         // transaction over, so money is refused
         dir_row(vcc_pkg::ACT_INSERT, 3'd0, 14'd0, 8'd0, 14'd7, 1'b1,
                 vcc_pkg::KIND_ERROR, 16'd0, 8'd0),
         dir_row(vcc_pkg::ACT_STOCK, 3'd5, 14'd0, 8'd255, 14'd0, 1'b0, '0, '0, '0),
         dir_row(vcc_pkg::ACT_LOAD, 3'd4, 14'd8191, 8'd128, 14'd8191, 1'b0, '0, '0, '0)
      };
      for (int i = 0; i < DIR_ROWS; i++) stim_plan.push_back(directed_tab[i]);

      gen_price = '{0, 0, 150, 0, 8191, 0, 0, 10000};
      rand_words = 0;
      r.fixed = 1'b0;
      r.fixed_rsp = '0;
      while (rand_words < RAND_WORDS) begin
         if ($urandom_range(0, 9) == 0) begin
            // stray word, any action
            r.word = mk_req(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                            14'($urandom_range(0, 10000)), 8'($urandom_range(0, 255)),
                            14'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 10000)
                                                            : $urandom_range(0, 500)));
            stim_plan.push_back(r);
            rand_words++;
         end else begin
            s = $urandom_range(0, 7);
            case ($urandom_range(0, 5))
               0, 1: begin
                  price = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10000)
                                                      : $urandom_range(0, 400);
                  stock = ($urandom_range(0, 4) == 0) ? 8'd0
                                                      : 8'($urandom_range(1, 255));
                  gen_price[s] = price;
                  r.word = mk_req(vcc_pkg::ACT_LOAD, 3'(s), 14'(price), stock,
                                  14'($urandom_range(0, 10000)));
                  stim_plan.push_back(r);
                  rand_words++;
               end
               2: begin
                  r.word = mk_req(vcc_pkg::ACT_STOCK, 3'(s), 14'($urandom_range(0, 10000)),
                                  8'($urandom_range(0, 3)), 14'($urandom_range(0, 10000)));
                  stim_plan.push_back(r);
                  rand_words++;
               end
               default: ;
            endcase
            r.word = mk_req(vcc_pkg::ACT_SELECT, 3'(s), 14'($urandom_range(0, 10000)),
                            8'($urandom_range(0, 255)), 14'($urandom_range(0, 10000)));
            stim_plan.push_back(r);
            rand_words++;
            // pay until covered, a cancel, or the buyer wanders off
            paid  = 0;
            steps = 0;
            stop  = 1'b0;
            while (!stop) begin
               if ($urandom_range(0, 11) == 0)
                  amt = 0;
               else if ($urandom_range(0, 15) == 0)
                  amt = $urandom_range(0, 10000);
               else
                  amt = $urandom_range(1, gen_price[s] / 2 + 30);
               if (amt > 10000) amt = 10000;
               r.word = mk_req(vcc_pkg::ACT_INSERT, 3'($urandom_range(0, 7)),
                               14'($urandom_range(0, 10000)), 8'($urandom_range(0, 255)),
                               14'(amt));
               stim_plan.push_back(r);
               rand_words++;
               steps++;
               if (amt == 0 && paid == 0) stop = 1'b1;
               paid = paid + amt;
               if (paid >= gen_price[s] || steps >= 6) stop = 1'b1;
            end
         end
      end
   endtask

   // request side: bursts of random length with random gaps
   initial begin
      int burst_left;
      int gap;
      req_valid <= 1'b0;
      req_word  <= '0;
      taken_count    = 0;
      mismatch_count = 0;
      build_plan();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      burst_left = 0;
      for (int i = 0; i < stim_plan.size(); i++) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
         end
         req_valid <= 1'b1;
         req_word  <= stim_plan[i].word;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         burst_left--;
      end
      req_valid <= 1'b0;

      // drain
      while (due_words.size() != 0 || taken_count < stim_plan.size()) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // response side: rotating stall patterns and one long hold-off
   initial begin
      int cyc;
      rsp_ready <= 1'b0;
      while (reset) @(posedge clock);
      cyc = 0;
      forever begin
         if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN)
            rsp_ready <= 1'b0;
         else begin
            case ((cyc / 97) % 4)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 1) == 1);
               2:       rsp_ready <= (cyc % 4 != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
         @(posedge clock);
         cyc++;
      end
   end

   // check response words, then predict for the request taken at this edge
   always @(posedge clock) begin
      vcc_pkg::vcc_rsp_type want;
      vcc_pkg::vcc_rsp_type w;
      stim_row_type         row;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_words.size() == 0) begin
            report_mismatch("unexpected word, kind", int'(rsp_word.kind), -1);
         end else begin
            want = due_words.pop_front();
            match_field("kind", int'(rsp_word.kind), int'(want.kind));
            match_field("coin_value", int'(rsp_word.coin_value), int'(want.coin_value));
            match_field("coin_count", int'(rsp_word.coin_count), int'(want.coin_count));
            match_field("money_cents", int'(rsp_word.money_cents), int'(want.money_cents));
            match_field("stock_left", int'(rsp_word.stock_left), int'(want.stock_left));
            match_field("last", int'(rsp_word.last), int'(want.last));
         end
      end
      if (!reset && req_valid && req_ready) begin
         row = stim_plan[taken_count];
         taken_count++;
         vend_forecast(row.word);
         if (row.fixed) begin
            due_words.push_back(row.fixed_rsp);
         end else begin
            for (int i = 0; i < word_cnt; i++) begin
               w = word_buf[i];
               w.last = (i == word_cnt - 1);
               due_words.push_back(w);
            end
         end
      end
   end

   // model reset
   initial begin
      for (int i = 0; i < 8; i++) begin
         price_mem[i] = '0;
         stock_mem[i] = '0;
      end
      pick_slot  = '0;
      pick_valid = 1'b0;
      paid_sum   = '0;
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule

>>> files.f
sv/vcc_pkg.sv
sv/vcc_ctrl.sv
sv/vcc_datapath.sv
sv/vending_controller_with_change_unit.sv
tb/sv/vending_controller_with_change_unit_tb.sv
